### hw/rtl/cbmf_pkg.sv
// Shared types and constants for the complement byte message framer.
// Used by every module of the block; no dependencies.
package cbmf_pkg;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_LAST   = 2'd1;
  localparam logic [1:0] OP_EMPTY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'hFF;
  localparam logic [7:0] HDR2 = 8'h00;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] payload_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic       hdr;
    logic       pay;
    logic       tail;
    logic [7:0] pb;
    logic [7:0] sum;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [6:0] {
    PH_H0 = 7'b0000001,
    PH_H1 = 7'b0000010,
    PH_H2 = 7'b0000100,
    PH_PB = 7'b0001000,
    PH_PC = 7'b0010000,
    PH_SM = 7'b0100000,
    PH_SC = 7'b1000000
  } phase_e;

endpackage

### hw/rtl/complement_byte_message_framer_top.sv
// Top level of the complement byte message framer: front end, command queue,
// back end. Depends on cbmf_pkg, cbmf_front, cbmf_queue and cbmf_back.
//
// Each input transfer becomes a run of line bytes sent at one byte per cycle,
// when the output is not stalled, through a registered output: a payload byte
// inside a frame becomes the byte and its complement, the first item of a frame
// adds three header bytes, and a last-byte or empty-message item adds the
// checksum and its complement (so 2 to 7 line bytes per item). A two-entry
// command queue lets new input transfers be taken while earlier bytes are still
// going out. Opcode 3 is taken and dropped without output or state change.
module complement_byte_message_framer_top import cbmf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  q_stat_t q_stat;
  logic    push, pop;
  cmd_t    push_cmd, head_cmd;

  cbmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  cbmf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .stat_o      (q_stat)
  );

  cbmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_end |-> out_o.run_last)
    else $error("frame end byte not marked as last of its run");

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.opcode == OP_UNUSED |-> !push)
    else $error("unused opcode produced a command");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

### hw/rtl/cbmf_front.sv
// Front end: accepts input transfers, tracks frame state and running sum,
// and turns each item but opcode 3 into a queue command. Depends on cbmf_pkg.
module cbmf_front import cbmf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_t     in_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] sum_q, sum_d;
  logic       accept;
  logic [7:0] sum_new;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign push_o     = accept && (in_i.opcode != OP_UNUSED);

  always_comb begin
    cmd_o.hdr  = !in_frame_q;
    cmd_o.pay  = (in_i.opcode != OP_EMPTY);
    cmd_o.tail = (in_i.opcode != OP_BYTE);
    cmd_o.pb   = in_i.payload_byte;
    sum_new    = (in_frame_q ? sum_q : 8'h00) + (cmd_o.pay ? in_i.payload_byte : 8'h00);
    cmd_o.sum  = sum_new;
    in_frame_d = in_frame_q;
    sum_d      = sum_q;
    if (push_o) begin
      in_frame_d = !cmd_o.tail;
      sum_d      = cmd_o.tail ? 8'h00 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      sum_q      <= 8'h00;
    end else begin
      in_frame_q <= in_frame_d;
      sum_q      <= sum_d;
    end
  end

endmodule

### hw/rtl/cbmf_queue.sv
// Short command queue between front and back end.
// Depends on cbmf_pkg for the command type and depth.
module cbmf_queue import cbmf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_data_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/cbmf_back.sv
// Back end: walks the head command through its line bytes, one per cycle
// while the output is not stalled, into the output register. Depends on cbmf_pkg.
module cbmf_back import cbmf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    head_i,
  input  q_stat_t q_stat_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output out_t    out_o
);

  phase_e     step_q, step_d, first_ph, cur, nxt;
  logic       started_q, started_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       load, last;
  logic [7:0] byte_v;

  always_comb begin
    first_ph = head_i.hdr ? PH_H0 : (head_i.pay ? PH_PB : PH_SM);
    cur      = started_q ? step_q : first_ph;
    nxt      = PH_H0;
    last     = 1'b0;
    byte_v   = 8'h00;
    case (cur)
      PH_H0: begin byte_v = HDR0; nxt = PH_H1; end
      PH_H1: begin byte_v = HDR1; nxt = PH_H2; end
      PH_H2: begin
        byte_v = HDR2;
        nxt    = head_i.pay ? PH_PB : PH_SM;
      end
      PH_PB: begin byte_v = head_i.pb; nxt = PH_PC; end
      PH_PC: begin
        byte_v = ~head_i.pb;
        nxt    = PH_SM;
        last   = !head_i.tail;
      end
      PH_SM: begin byte_v = head_i.sum; nxt = PH_SC; end
      PH_SC: begin byte_v = ~head_i.sum; last = 1'b1; end
      default: begin byte_v = 8'h00; last = 1'b1; end
    endcase
  end

  assign load  = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    step_d      = step_q;
    started_d   = started_q;
    if (load) begin
      out_valid_d     = 1'b1;
      out_d.line_byte = byte_v;
      out_d.run_last  = last;
      out_d.frame_end = (cur == PH_SC);
      started_d       = !last;
      step_d          = nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      step_q      <= PH_H0;
    end else begin
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      step_q      <= step_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### test/complement_byte_message_framer_top_tb.sv
// Self-checking testbench for complement_byte_message_framer_top.
// Predicts the framed line bytes of every input transfer and checks them in order;
// depends on cbmf_pkg and the framer RTL only.
module complement_byte_message_framer_top_tb;
  import cbmf_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int DrainCycles = 24;
  localparam int HoldCycles  = 90;
  localparam int LimitTime   = 3_000_000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PATTERN
  } rx_mode_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  out_t     expected_line_q[$];
  logic     model_in_frame  = 1'b0;
  logic [7:0] model_frame_sum = 8'h00;

  int       mismatch_count  = 0;
  int       bytes_checked   = 0;
  int       items_sent      = 0;
  int       frames_closed   = 0;

  logic     tx_idle_on      = 1'b0;
  int       tx_burst_left   = 0;
  rx_mode_e rx_mode         = RX_OPEN;
  logic     rx_hold_req     = 1'b0;

  complement_byte_message_framer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LimitTime);
    $display("%0t: timeout with %0d line bytes still expected", $time,
             expected_line_q.size());
    $display("status: fail");
    $finish;
  end

  function automatic out_t line_byte_of(logic [7:0] value, logic closes);
    out_t b;
    b.line_byte = value;
    b.run_last  = 1'b0;
    b.frame_end = closes;
    return b;
  endfunction

  function automatic void frame_line_bytes(in_t item);
    out_t run_q[$];
    if (item.opcode == OP_UNUSED) return;
    if (!model_in_frame) begin
      run_q.push_back(line_byte_of(HDR0, 1'b0));
      run_q.push_back(line_byte_of(HDR1, 1'b0));
      run_q.push_back(line_byte_of(HDR2, 1'b0));
      model_in_frame  = 1'b1;
      model_frame_sum = 8'h00;
    end
    if (item.opcode != OP_EMPTY) begin
      run_q.push_back(line_byte_of(item.payload_byte, 1'b0));
      run_q.push_back(line_byte_of(~item.payload_byte, 1'b0));
      model_frame_sum = model_frame_sum + item.payload_byte;
    end
    if (item.opcode != OP_BYTE) begin
      run_q.push_back(line_byte_of(model_frame_sum, 1'b0));
      run_q.push_back(line_byte_of(~model_frame_sum, 1'b1));
      model_in_frame  = 1'b0;
      model_frame_sum = 8'h00;
      frames_closed++;
    end
    run_q[run_q.size() - 1].run_last = 1'b1;
    foreach (run_q[k]) expected_line_q.push_back(run_q[k]);
  endfunction

  function automatic in_t make_item(logic [1:0] op, logic [7:0] pb);
    in_t item;
    item.opcode       = op;
    item.payload_byte = pb;
    return item;
  endfunction

  function automatic int next_gap();
    if (!tx_idle_on) return 0;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return 0;
    end
    tx_burst_left = $urandom_range(0, 10);
    return $urandom_range(1, 6);
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (in_stall_o);
    frame_line_bytes(item);
    items_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_line_q.size() != 0);
  endtask

  initial begin : rx_stall_gen
    int  run_left;
    logic stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_mode == RX_PATTERN) begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        run_left--;
        out_stall_i <= stalling;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : line_byte_checker
    out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_line_q.size() == 0) begin
          $display("%0t: unexpected line byte, actual %02h run_last %0b frame_end %0b",
                   $time, out_o.line_byte, out_o.run_last, out_o.frame_end);
          mismatch_count++;
        end else begin
          want = expected_line_q.pop_front();
          bytes_checked++;
          if (out_o.line_byte !== want.line_byte) begin
            $display("%0t: line_byte expected %02h actual %02h", $time,
                     want.line_byte, out_o.line_byte);
            mismatch_count++;
          end
          if (out_o.run_last !== want.run_last) begin
            $display("%0t: run_last expected %0b actual %0b", $time,
                     want.run_last, out_o.run_last);
            mismatch_count++;
          end
          if (out_o.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $time,
                     want.frame_end, out_o.frame_end);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic test_header_and_empty();
    tx_idle_on = 1'b0;
    rx_mode    = RX_OPEN;
    send_item(make_item(OP_EMPTY, 8'h00));
    send_item(make_item(OP_EMPTY, 8'hFF));
    send_item(make_item(OP_LAST, 8'h00));
    send_item(make_item(OP_LAST, 8'hFF));
  endtask

  task automatic test_sum_wrap();
    tx_idle_on = 1'b1;
    send_item(make_item(OP_BYTE, 8'hFF));
    send_item(make_item(OP_BYTE, 8'hFF));
    send_item(make_item(OP_BYTE, 8'h80));
    send_item(make_item(OP_LAST, 8'h81));
  endtask

  task automatic test_empty_closes_open_frame();
    rx_mode = RX_PATTERN;
    send_item(make_item(OP_BYTE, 8'hA5));
    send_item(make_item(OP_EMPTY, 8'h5A));
    send_item(make_item(OP_BYTE, 8'h01));
    send_item(make_item(OP_BYTE, 8'h02));
    send_item(make_item(OP_EMPTY, 8'h00));
  endtask

  task automatic test_unused_opcode();
    send_item(make_item(OP_UNUSED, 8'h3C));
    send_item(make_item(OP_BYTE, 8'h12));
    send_item(make_item(OP_UNUSED, 8'hC3));
    send_item(make_item(OP_UNUSED, 8'hFF));
    send_item(make_item(OP_LAST, 8'h00));
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering back to back.
  task automatic test_receiver_hold();
    int k;
    tx_idle_on  = 1'b0;
    rx_mode     = RX_OPEN;
    rx_hold_req = 1'b1;
    for (k = 0; k < 13; k++) send_item(make_item(OP_BYTE, 8'($urandom)));
    send_item(make_item(OP_LAST, 8'($urandom)));
    wait_drained();
  endtask

  task automatic test_drain_pause();
    rx_mode = RX_PATTERN;
    send_item(make_item(OP_BYTE, 8'($urandom)));
    send_item(make_item(OP_BYTE, 8'($urandom)));
    send_item(make_item(OP_LAST, 8'($urandom)));
    wait_drained();
    send_item(make_item(OP_EMPTY, 8'($urandom)));
    wait_drained();
  endtask

  task automatic test_random_frames(input int n_items);
    int   sent;
    int   shape;
    int   len;
    int   k;
    logic [1:0] op;
    sent = 0;
    while (sent < n_items) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_mode    = ($urandom_range(0, 4) != 0) ? RX_PATTERN : RX_OPEN;
      shape      = $urandom_range(0, 99);
      if (shape < 8) begin
        send_item(make_item(OP_UNUSED, 8'($urandom)));
      end else if (shape < 16) begin
        send_item(make_item(OP_EMPTY, 8'($urandom)));
        sent++;
      end else begin
        len = (shape < 20) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 24) == 0) send_item(make_item(OP_UNUSED, 8'($urandom)));
          op = (k == len - 1) ? OP_LAST : OP_BYTE;
          if (op == OP_BYTE && $urandom_range(0, 29) == 0) begin
            send_item(make_item(OP_EMPTY, 8'($urandom)));
            sent++;
            break;
          end
          send_item(make_item(op, 8'($urandom)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_header_and_empty();
    test_sum_wrap();
    test_empty_closes_open_frame();
    test_unused_opcode();
    test_receiver_hold();
    test_drain_pause();
    test_random_frames(130);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d input transfers, %0d frames closed, %0d line bytes checked",
             items_sent, frames_closed, bytes_checked);
    $display("including a long receiver hold, a full drain pause and unused opcodes");
    if (mismatch_count == 0 && expected_line_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
